### sv/hcm_pkg.sv
// Shared types, constants and helper functions of the heightmap contour marker.
// No dependencies; every other file of the block imports this package.
package hcm_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 16;
    localparam int HGT_W       = 8;
    localparam int PIX_W       = HGT_W + 1;
    localparam int CFG_W_W     = 13;
    localparam int CFG_H_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = ((COL_W + ROW_W + 1 + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - (COL_W + ROW_W + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W_W-1:0] RESET_IMAGE_WIDTH  = CFG_W_W'(4096);
    localparam logic [CFG_H_W-1:0] RESET_IMAGE_HEIGHT = CFG_H_W'(4096);

    localparam logic [2:0] CONTOUR_RESIDUE = 3'd3;

    // Results decided by one pixel: bit 0 is the pixel above, bit 1 the pixel
    // to the left on the last row, bit 2 the last pixel of the frame.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [2:0]       vld;
        logic [2:0]       ct;
    } t_bundle;

    // Height modulo five, using 16 = 1 (mod 5) to fold the nibbles.
    function automatic logic [2:0] mod5(input logic [HGT_W-1:0] v);
        logic [4:0] s;
        logic [4:0] t;
        begin
            s = {1'b0, v[7:4]} + {1'b0, v[3:0]};
            t = {4'b0, s[4]} + {1'b0, s[3:0]};
            if (t >= 5'd15) begin
                t = t - 5'd15;
            end else if (t >= 5'd10) begin
                t = t - 5'd10;
            end else if (t >= 5'd5) begin
                t = t - 5'd5;
            end
            return t[2:0];
        end
    endfunction

    function automatic logic is_contour(
        input logic [PIX_W-1:0] self,
        input logic [3:0]       ok,
        input logic [HGT_W-1:0] nb0,
        input logic [HGT_W-1:0] nb1,
        input logic [HGT_W-1:0] nb2,
        input logic [HGT_W-1:0] nb3
    );
        logic [HGT_W-1:0] h;
        logic             lower;
        begin
            h     = self[HGT_W-1:0];
            lower = (ok[0] && (nb0 < h)) || (ok[1] && (nb1 < h)) ||
                    (ok[2] && (nb2 < h)) || (ok[3] && (nb3 < h));
            return self[HGT_W] && (mod5(h) == CONTOUR_RESIDUE) && lower;
        end
    endfunction

endpackage

### sv/heightmap_contour_marker.sv
// Heightmap contour marker: pixel stream in, contour decisions out.
// Pixels enter on the s_axis channel in raster order, one request per pixel.
// Each pixel decides up to three results: the pixel above it, and on the last
// row also the pixel to its left and, at the frame end, the pixel itself.
// Results leave on m_axis in raster order of the decided pixels; tlast marks
// the final result of one input pixel.
// Throughput is one pixel per cycle while each pixel yields at most one
// result and m_axis does not stall; on the last row below the first each
// pixel after column 0 yields two results, or three at the frame end, so
// the output port sets the pace there. Unless the frame has only one row,
// the first row yields no results. An accepted pixel reaches m_axis through
// the decision stage writing the queue, the back part taking the bundle and
// the output register. The user must write image width and height on the
// cfg channel only while idle; the block itself does not enforce this.
// Reset clears the position to row 0, column 0 and sets both sizes to 4096.
// The line buffers hold whatever they held; entries are written before use.
// When m_axis stalls, the bundle queue of four entries fills and then
// s_axis_tready drops; no result is lost.
// Depends on hcm_pkg, hcm_front, hcm_queue and hcm_back.
module heightmap_contour_marker import hcm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: height[7:0], coverage[15:8].
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: out_col[11:0], out_row[27:12], contour[28], zero pad.
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    t_bundle          push_data;
    t_bundle          head_data;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             contour;

    assign o_cfg_ready = 1'b1;

    hcm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_height   (s_axis_tdata[HGT_W-1:0]),
        .i_coverage (s_axis_tdata[2*HGT_W-1:HGT_W]),
        .o_push     (push),
        .o_bundle   (push_data),
        .i_q_full   (q_full)
    );

    hcm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_data),
        .o_full (q_full),
        .i_pop  (pop),
        .o_empty(q_empty),
        .o_data (head_data)
    );

    hcm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_q_data (head_data),
        .o_q_pop  (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_col    (out_col),
        .o_row    (out_row),
        .o_contour(contour),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, contour, out_row, out_col};

endmodule

### sv/hcm_queue.sv
// Short queue of decided result bundles between the front and back parts.
// Depends on hcm_pkg for the bundle type and queue depth.
module hcm_queue import hcm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_bundle o_data
);

    t_bundle           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_head];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (do_pop) begin
                r_head <= r_head + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### sv/hcm_front.sv
// Front part: accepts pixels, tracks position, keeps the two line buffers and
// decides contour flags, pushing one bundle per pixel that decides anything.
// Depends on hcm_pkg.
module hcm_front import hcm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [HGT_W-1:0]      i_height,
    input  logic [HGT_W-1:0]      i_coverage,
    output logic                  o_push,
    output t_bundle               o_bundle,
    input  logic                  i_q_full
);

    logic [CFG_W_W-1:0] r_cfg_w;
    logic [CFG_H_W-1:0] r_cfg_h;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;

    // Line buffers: most recent row (height plus coverage flag) and the one before.
    logic [PIX_W-1:0] prev_mem  [MAX_WIDTH];
    logic [HGT_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_p0;
    logic [PIX_W-1:0] r_rd_p1;
    logic [HGT_W-1:0] r_rd_o0;
    logic             r_byp_p0;
    logic             r_byp_p1;
    logic             r_byp_o0;
    logic [PIX_W-1:0] r_wd_prev;
    logic [HGT_W-1:0] r_wd_older;

    logic             r_s1_valid;
    logic [HGT_W-1:0] r_s1_h;
    logic             r_s1_cov;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_lastrow;
    logic             r_s1_lastcol;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_left2;
    logic [HGT_W-1:0] r_up_left;

    logic [CFG_W_W-1:0] w_eff;
    logic [CFG_W_W-1:0] w_m1;
    logic [CFG_H_W-1:0] h_m1;
    logic               lastcol;
    logic               lastrow;
    logic               accept;
    logic               s1_adv;
    logic               we;
    logic [COL_W-1:0]   ra0;
    logic [COL_W-1:0]   ra1;
    logic [PIX_W-1:0]   cur;
    logic [PIX_W-1:0]   p0;
    logic [PIX_W-1:0]   p1;
    logic [HGT_W-1:0]   o0;
    t_bundle            bun;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = CFG_W_W'(1);
        end else if (r_cfg_w > CFG_W_W'(MAX_WIDTH)) begin
            w_eff = CFG_W_W'(MAX_WIDTH);
        end else begin
            w_eff = r_cfg_w;
        end
        w_m1 = w_eff - 1'b1;
        h_m1 = (r_cfg_h == '0) ? '0 : r_cfg_h - 1'b1;
    end

    assign lastcol    = {{(CFG_W_W-COL_W){1'b0}}, r_col} >= w_m1;
    assign lastrow    = r_row >= h_m1;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign ra0        = r_col;
    assign ra1        = r_col + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RESET_IMAGE_WIDTH;
            r_cfg_h <= RESET_IMAGE_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data[CFG_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (lastcol) begin
                r_col <= '0;
                r_row <= lastrow ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Memories: written by the pixel leaving stage one, read by the pixel entering it.
    always_ff @(posedge i_clk) begin
        if (we) begin
            prev_mem[r_s1_col] <= cur;
        end
        if (accept) begin
            r_rd_p0 <= prev_mem[ra0];
            r_rd_p1 <= prev_mem[ra1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            older_mem[r_s1_col] <= p0[HGT_W-1:0];
        end
        if (accept) begin
            r_rd_o0 <= older_mem[ra0];
        end
    end

    // A write in the same cycle as the read wins over the stale memory word.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_wd_prev  <= cur;
            r_wd_older <= p0[HGT_W-1:0];
        end
        if (accept) begin
            r_byp_p0 <= we && (r_s1_col == ra0);
            r_byp_p1 <= we && (r_s1_col == ra1);
            r_byp_o0 <= we && (r_s1_col == ra0);
        end
    end

    assign p0 = r_byp_p0 ? r_wd_prev  : r_rd_p0;
    assign p1 = r_byp_p1 ? r_wd_prev  : r_rd_p1;
    assign o0 = r_byp_o0 ? r_wd_older : r_rd_o0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_h       <= i_height;
            r_s1_cov     <= (i_coverage != '0);
            r_s1_col     <= r_col;
            r_s1_row     <= r_row;
            r_s1_lastrow <= lastrow;
            r_s1_lastcol <= lastcol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_left2   <= '0;
            r_up_left <= '0;
        end else if (we) begin
            r_left    <= cur;
            r_left2   <= r_left;
            r_up_left <= p0[HGT_W-1:0];
        end
    end

    always_comb begin
        cur        = {r_s1_cov, r_s1_h};
        bun.col    = r_s1_col;
        bun.row    = r_s1_row;
        bun.vld[0] = (r_s1_row != '0);
        bun.vld[1] = r_s1_lastrow && (r_s1_col != '0);
        bun.vld[2] = r_s1_lastrow && r_s1_lastcol;
        bun.ct[0]  = is_contour(p0,
                         {1'b1, !r_s1_lastcol, (r_s1_col != '0), (r_s1_row > ROW_W'(1))},
                         o0, r_up_left, p1[HGT_W-1:0], r_s1_h);
        bun.ct[1]  = is_contour(r_left,
                         {1'b0, 1'b1, (r_s1_col > COL_W'(1)), (r_s1_row != '0)},
                         r_up_left, r_left2[HGT_W-1:0], r_s1_h, r_s1_h);
        bun.ct[2]  = is_contour(cur,
                         {1'b0, 1'b0, (r_s1_col != '0), (r_s1_row != '0)},
                         p0[HGT_W-1:0], r_left[HGT_W-1:0], r_s1_h, r_s1_h);
    end

    assign s1_adv   = r_s1_valid && ((bun.vld == '0) || !i_q_full);
    assign we       = s1_adv;
    assign o_push   = s1_adv && (bun.vld != '0);
    assign o_bundle = bun;

endmodule

### sv/hcm_back.sv
// Back part: takes bundles from the queue and sends their results one a cycle
// while i_ready holds, through a registered output stage. Depends on hcm_pkg.
module hcm_back import hcm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_bundle          i_q_data,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [COL_W-1:0] o_col,
    output logic [ROW_W-1:0] o_row,
    output logic             o_contour,
    output logic             o_last
);

    t_bundle          r_bun;
    logic [2:0]       r_pend;
    logic             r_out_valid;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_ct;
    logic             r_last;

    logic             load_out;
    logic             emit;
    logic [2:0]       sel;
    logic [2:0]       rem;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic             n_ct;

    assign load_out = !r_out_valid || i_ready;
    assign emit     = load_out && (r_pend != '0);
    assign sel      = r_pend & (~r_pend + 3'd1);
    assign rem      = r_pend & ~sel;
    assign o_q_pop  = !i_q_empty && ((r_pend == '0) || (emit && (rem == '0)));

    always_comb begin
        n_col = r_bun.col;
        n_row = r_bun.row;
        n_ct  = r_bun.ct[2];
        case (sel)
            3'b001: begin
                n_row = r_bun.row - 1'b1;
                n_ct  = r_bun.ct[0];
            end
            3'b010: begin
                n_col = r_bun.col - 1'b1;
                n_ct  = r_bun.ct[1];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (o_q_pop) begin
            r_pend <= i_q_data.vld;
        end else if (emit) begin
            r_pend <= rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_bun <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_ct   <= n_ct;
            r_last <= (rem == '0);
        end
    end

    assign o_valid   = r_out_valid;
    assign o_col     = r_col;
    assign o_row     = r_row;
    assign o_contour = r_ct;
    assign o_last    = r_last;

endmodule

### test/heightmap_contour_marker_tb.sv
// Self-checking testbench for heightmap_contour_marker: streams pixel frames in
// raster order and checks every contour decision against a behavioral predictor.
// Depends on hcm_pkg and the heightmap_contour_marker RTL.
module heightmap_contour_marker_tb;
    import hcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             mark;
        logic             last;
    } t_decision;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Predictor state: sizes, raster position and the two rows above.
    int          cfg_width = 4096;
    int          cfg_height = 4096;
    int          col_pos = 0;
    int          row_pos = 0;
    logic [8:0]  west_px = '0;
    logic [8:0]  line_above [MAX_WIDTH];
    logic [7:0]  line_two_up [MAX_WIDTH];

    t_decision   pending_decisions [$];
    int          errors = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;

    heightmap_contour_marker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #4ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [8:0] above_px(input int i);
        return (i >= 0 && i < MAX_WIDTH) ? line_above[i] : 9'd0;
    endfunction

    function automatic logic [7:0] two_up_h(input int i);
        return (i >= 0 && i < MAX_WIDTH) ? line_two_up[i] : 8'd0;
    endfunction

    // Neighbour k is present when ok[k]; its height sits in nb[8k+7:8k].
    function automatic logic contour_of(input logic [8:0] px, input logic [3:0] ok,
                                        input logic [31:0] nb);
        logic lower;
        lower = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (ok[k] && nb[8*k +: 8] < px[7:0]) begin
                lower = 1'b1;
            end
        end
        return px[8] && (px[7:0] % 5 == 3) && lower;
    endfunction

    function automatic t_decision decide(input int col, input int row, input logic mark);
        t_decision d;
        d.col  = COL_W'(col);
        d.row  = ROW_W'(row);
        d.mark = mark;
        d.last = 1'b0;
        return d;
    endfunction

    task automatic predict_decisions(input logic [7:0] h, input logic [7:0] cov);
        int          w;
        int          hg;
        int          c;
        int          r;
        logic [8:0]  cur;
        logic [8:0]  right_px;
        logic [8:0]  left2_px;
        logic        lastrow;
        logic        lastcol;
        t_decision   found [$];
        w  = cfg_width;
        hg = cfg_height;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (hg < 1) hg = 1;
        c = col_pos;
        r = row_pos;
        cur = {cov != 8'd0, h};
        lastrow = (r >= hg - 1);
        lastcol = (c >= w - 1);

        // The new pixel completes the neighbourhood of the one above it.
        if (r >= 1) begin
            right_px = above_px(c + 1);
            found.push_back(decide(c, r - 1, contour_of(above_px(c),
                {1'b1, c + 1 < w, c >= 1, r >= 2},
                {h, right_px[7:0], (c >= 1) ? two_up_h(c - 1) : 8'd0, two_up_h(c)})));
        end

        if (c < MAX_WIDTH) begin
            line_two_up[c] = line_above[c][7:0];
            line_above[c]  = cur;
        end

        // On the last row nothing arrives below, so the left pixel is done now.
        if (lastrow && c >= 1) begin
            left2_px = above_px(c - 2);
            found.push_back(decide(c - 1, r, contour_of(west_px,
                {1'b0, 1'b1, c >= 2, r >= 1},
                {8'd0, h, (c >= 2) ? left2_px[7:0] : 8'd0, two_up_h(c - 1)})));
        end

        if (lastrow && lastcol) begin
            found.push_back(decide(c, r, contour_of(cur,
                {1'b0, 1'b0, c >= 1, r >= 1},
                {8'd0, 8'd0, west_px[7:0], two_up_h(c)})));
        end

        west_px = cur;
        if (lastcol) begin
            col_pos = 0;
            row_pos = lastrow ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end

        if (found.size() > 0) begin
            found[found.size() - 1].last = 1'b1;
        end
        foreach (found[i]) begin
            pending_decisions.push_back(found[i]);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_decision want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_decisions.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual data %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_decisions.pop_front();
                if (m_axis_tdata[COL_W-1:0] !== want.col) begin
                    errors++;
                    $display("%0t: out_col expected %0d actual %0d", $time, want.col,
                             m_axis_tdata[COL_W-1:0]);
                end
                if (m_axis_tdata[COL_W +: ROW_W] !== want.row) begin
                    errors++;
                    $display("%0t: out_row expected %0d actual %0d", $time, want.row,
                             m_axis_tdata[COL_W +: ROW_W]);
                end
                if (m_axis_tdata[COL_W+ROW_W] !== want.mark) begin
                    errors++;
                    $display("%0t: contour at (%0d,%0d) expected %b actual %b", $time,
                             want.row, want.col, want.mark, m_axis_tdata[COL_W+ROW_W]);
                end
                if (m_axis_tdata[OUT_DATA_W-1:COL_W+ROW_W+1] !== '0) begin
                    errors++;
                    $display("%0t: padding expected 0 actual %h", $time,
                             m_axis_tdata[OUT_DATA_W-1:COL_W+ROW_W+1]);
                end
                if (m_axis_tlast !== want.last) begin
                    errors++;
                    $display("%0t: last_of_run expected %b actual %b", $time, want.last,
                             m_axis_tlast);
                end
            end
        end
    end

    task automatic push_pixel(input logic [7:0] h, input logic [7:0] cov);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cov, h};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_decisions(h, cov);
    endtask

    // Stops the pixel stream and waits for every outstanding decision, then
    // lets the pipeline run dry since first-row pixels produce no result.
    task automatic wait_results_done();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_decisions.size() != 0 && guard < 40000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_decisions.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived, next (%0d,%0d) actual none",
                     $time, pending_decisions.size(), pending_decisions[0].row,
                     pending_decisions[0].col);
            pending_decisions.delete();
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_IMAGE_WIDTH) begin
            cfg_width = int'(value[CFG_W_W-1:0]);
        end else begin
            cfg_height = int'(value[CFG_H_W-1:0]);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input int w, input int hg);
        wait_results_done();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(hg));
    endtask

    function automatic logic [15:0] random_pixel();
        logic [7:0] h;
        logic [7:0] cov;
        int         pick;
        pick = $urandom_range(9);
        if (pick < 4) begin
            h = 8'($urandom_range(255));
        end else if (pick < 7) begin
            h = 8'(5 * $urandom_range(50) + 3);
        end else begin
            h = 8'($urandom_range(16, 30));
        end
        pick = $urandom_range(9);
        if (pick < 2) begin
            cov = 8'd0;
        end else if (pick < 3) begin
            cov = 8'd255;
        end else begin
            cov = 8'($urandom_range(1, 255));
        end
        return {cov, h};
    endfunction

    // Starts on the reset sizes, then shrinks both sizes partway through the
    // first row so that the row and the frame end early.
    task automatic test_reset_sizes();
        push_pixel(8'd13, 8'd255);
        push_pixel(8'd8, 8'd255);
        push_pixel(8'd3, 8'd1);
        push_pixel(8'd18, 8'd0);
        wait_results_done();
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        push_pixel(8'd2, 8'd255);
        push_pixel(8'd248, 8'd128);
        push_pixel(8'd253, 8'd77);
        wait_results_done();
        write_reg(REG_IMAGE_WIDTH, 16'd4);
        push_pixel(8'd250, 8'd255);
    endtask

    // Largest and zero register values, single-pixel frames and one-column
    // frames, with the height cut short in the middle of a frame.
    task automatic test_size_extremes();
        set_frame(8191, 65535);
        push_pixel(8'd28, 8'd200);
        push_pixel(8'd0, 8'd0);
        push_pixel(8'd33, 8'd9);
        wait_results_done();
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        push_pixel(8'd38, 8'd1);
        push_pixel(8'd43, 8'd64);
        wait_results_done();
        write_reg(REG_IMAGE_WIDTH, 16'd0);
        push_pixel(8'd255, 8'd255);
        wait_results_done();
        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        push_pixel(8'd3, 8'd255);
        push_pixel(8'd8, 8'd0);
        set_frame(1, 65535);
        push_pixel(8'd23, 8'd10);
        push_pixel(8'd18, 8'd20);
        push_pixel(8'd28, 8'd30);
        push_pixel(8'd13, 8'd40);
        wait_results_done();
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        push_pixel(8'd53, 8'd50);
    endtask

    task automatic test_small_frame();
        set_frame(3, 3);
        push_pixel(8'd13, 8'd1);
        push_pixel(8'd3, 8'd255);
        push_pixel(8'd18, 8'd0);
        push_pixel(8'd253, 8'd128);
        push_pixel(8'd8, 8'd255);
        push_pixel(8'd255, 8'd2);
        push_pixel(8'd0, 8'd255);
        push_pixel(8'd248, 8'd200);
        push_pixel(8'd23, 8'd77);
    endtask

    task automatic test_random_frames(input int src_pct, input int sink_pct, input int budget);
        int         sent;
        int         w;
        int         hg;
        logic [15:0] px;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        while (sent < budget) begin
            // Half of the frames reuse the current size and stream back to back.
            if ($urandom_range(1) == 0 || sent == 0) begin
                if ($urandom_range(9) == 0) begin
                    w  = $urandom_range(20, 48);
                    hg = $urandom_range(1, 3);
                end else begin
                    w  = $urandom_range(1, 10);
                    hg = $urandom_range(1, 6);
                end
                set_frame(w, hg);
            end
            repeat (cfg_width * cfg_height) begin
                px = random_pixel();
                push_pixel(px[7:0], px[15:8]);
            end
            sent += cfg_width * cfg_height;
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            line_above[i]  = '0;
            line_two_up[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_sizes();
        test_size_extremes();
        test_small_frame();
        test_random_frames(0, 0, 60);
        test_random_frames(64, 0, 60);
        test_random_frames(0, 64, 60);
        test_random_frames(29, 29, 60);

        wait_results_done();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
sv/hcm_pkg.sv
sv/hcm_queue.sv
sv/hcm_front.sv
sv/hcm_back.sv
sv/heightmap_contour_marker.sv
test/heightmap_contour_marker_tb.sv
